// ===== hw/rtl/utf8_to_ucs2_stream_decoder_top_assert.svh =====
// Assertion macros shared by the decoder modules.
// Each check runs on the rising edge of clk and is held off during reset.
`ifndef UTF8_TO_UCS2_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_TO_UCS2_STREAM_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define U8D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define U8D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/utf8dec_pkg.sv =====
package utf8dec_pkg;

  // Decoder modes
  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_NEED_ONE  = 3'd1,
    MODE_NEED_TWO  = 3'd2,
    MODE_NEED_LAST = 3'd3,
    MODE_SKIP      = 3'd4
  } mode_t;

  // One result item
  typedef struct packed {
    logic [15:0] code_unit;
    logic        last;
    logic [15:0] unit_count;
  } result_t;

  localparam int MAX_RESULTS = 3;

  // Results produced by one accepted byte
  typedef struct packed {
    logic [1:0]                   n;
    result_t [MAX_RESULTS-1:0]    res;
  } push_t;

  localparam logic [15:0] BAD_UNIT       = 16'h003F;
  localparam logic [15:0] LIMIT_RESET    = 16'd255;
  localparam int          FIFO_ADDR_W_DEF = 3;

  // Saturating increment of the unit counter
  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

// ===== hw/rtl/utf8_to_ucs2_stream_decoder_top.sv =====
// UTF-8 to UCS-2 stream decoder.
// Input channel (in_valid/in_ready/in_byte): one UTF-8 byte per request; a
// zero byte ends the string. Output channel (out_valid/out_ready): one UCS-2
// unit per request in code_unit; the string closes with a zero unit that has
// last set and unit_count holding the number of units before it.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes unit_limit, reset
// value 255; cfg_ready is always high. Write it only while the block is idle.
// A byte's results are registered into the queue when it is accepted.
// Throughput: one byte per cycle while in_ready is high; each byte gives
// zero to three results, the output side drains one result per cycle while
// out_ready is high, so the sustained rate is bounded by results per byte.
// Results sit in a small queue of 2**FIFO_ADDR_W entries; in_ready is high
// while at least three entries are free, so a receiver stall backs up into
// the queue and then holds off input. Nothing is lost or repeated.
// Reset (rst, synchronous) empties the queue, returns the decoder to idle
// with a zero unit count and restores the limit to 255.
module utf8_to_ucs2_stream_decoder_top #(
  parameter int FIFO_ADDR_W = utf8dec_pkg::FIFO_ADDR_W_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        last,
  output logic [15:0] unit_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  utf8dec_pkg::push_t push;
  logic               accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Decoder state and result generation
  utf8dec_core u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .push     (push)
  );

  // Result queue
  utf8dec_fifo #(
    .ADDR_W (FIFO_ADDR_W)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .space      (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_unit  (code_unit),
    .last       (last),
    .unit_count (unit_count)
  );

endmodule

// ===== hw/rtl/utf8dec_core.sv =====
module utf8dec_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  output utf8dec_pkg::push_t  push
);

  `include "utf8_to_ucs2_stream_decoder_top_assert.svh"

  utf8dec_pkg::mode_t decode_mode, decode_mode_next;
  logic [15:0] partial_value, partial_value_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [15:0] units_emitted, units_emitted_next;
  logic [15:0] unit_limit;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_limit <= utf8dec_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unit_limit <= cfg_data;
    end
  end

  // Decode one byte against the current state
  always_comb begin
    logic [1:0] cnt;
    logic       do_start;
    logic       do_close;
    cnt                = 2'd0;
    do_start           = 1'b0;
    do_close           = 1'b0;
    decode_mode_next   = decode_mode;
    partial_value_next = partial_value;
    held_byte_next     = held_byte;
    units_emitted_next = units_emitted;
    push               = '0;

    case (decode_mode)
      utf8dec_pkg::MODE_NEED_ONE: begin
        if (in_byte == 8'h00) begin
          push.res[cnt].code_unit = utf8dec_pkg::BAD_UNIT;
          cnt = cnt + 2'd1;
          units_emitted_next = utf8dec_pkg::sat_inc(units_emitted_next);
          do_close = 1'b1;
        end else begin
          push.res[cnt].code_unit = partial_value | {10'b0, in_byte[5:0]};
          cnt = cnt + 2'd1;
          units_emitted_next = utf8dec_pkg::sat_inc(units_emitted_next);
          decode_mode_next = utf8dec_pkg::MODE_IDLE;
        end
      end
      utf8dec_pkg::MODE_NEED_TWO: begin
        if (in_byte == 8'h00) begin
          push.res[cnt].code_unit = utf8dec_pkg::BAD_UNIT;
          cnt = cnt + 2'd1;
          units_emitted_next = utf8dec_pkg::sat_inc(units_emitted_next);
          do_close = 1'b1;
        end else begin
          held_byte_next   = in_byte;
          decode_mode_next = utf8dec_pkg::MODE_NEED_LAST;
        end
      end
      utf8dec_pkg::MODE_NEED_LAST: begin
        if (in_byte != 8'h00) begin
          push.res[cnt].code_unit = partial_value | {4'b0, held_byte[5:0], 6'b0}
                                    | {10'b0, in_byte[5:0]};
          cnt = cnt + 2'd1;
          units_emitted_next = utf8dec_pkg::sat_inc(units_emitted_next);
          decode_mode_next = utf8dec_pkg::MODE_IDLE;
        end else begin
          push.res[cnt].code_unit = utf8dec_pkg::BAD_UNIT;
          cnt = cnt + 2'd1;
          units_emitted_next = utf8dec_pkg::sat_inc(units_emitted_next);
          // held byte was not a continuation: below the limit, decode it again
          if (held_byte[7:6] != 2'b10 && units_emitted_next < unit_limit) begin
            push.res[cnt].code_unit = held_byte[7] ? utf8dec_pkg::BAD_UNIT
                                                   : {8'b0, held_byte};
            cnt = cnt + 2'd1;
            units_emitted_next = utf8dec_pkg::sat_inc(units_emitted_next);
          end
          do_close = 1'b1;
        end
      end
      utf8dec_pkg::MODE_SKIP: begin
        if (in_byte == 8'h00) begin
          do_close = 1'b1;
        end else if (in_byte[7:6] != 2'b10) begin
          do_start = 1'b1;
        end
      end
      default: begin
        if (in_byte == 8'h00) begin
          do_close = 1'b1;
        end else begin
          do_start = 1'b1;
        end
      end
    endcase

    // New character
    if (do_start) begin
      decode_mode_next = utf8dec_pkg::MODE_IDLE;
      if (units_emitted_next < unit_limit) begin
        if (in_byte inside {[8'h01:8'h7F]}) begin
          push.res[cnt].code_unit = {8'b0, in_byte};
          cnt = cnt + 2'd1;
          units_emitted_next = utf8dec_pkg::sat_inc(units_emitted_next);
        end else if (in_byte[7:5] == 3'b110) begin
          partial_value_next = {5'b0, in_byte[4:0], 6'b0};
          decode_mode_next   = utf8dec_pkg::MODE_NEED_ONE;
        end else if (in_byte[7:4] == 4'b1110) begin
          partial_value_next = {in_byte[3:0], 12'b0};
          decode_mode_next   = utf8dec_pkg::MODE_NEED_TWO;
        end else begin
          push.res[cnt].code_unit = utf8dec_pkg::BAD_UNIT;
          cnt = cnt + 2'd1;
          units_emitted_next = utf8dec_pkg::sat_inc(units_emitted_next);
          decode_mode_next = utf8dec_pkg::MODE_SKIP;
        end
      end
    end

    // Terminator closes the string
    if (do_close) begin
      push.res[cnt].code_unit  = 16'h0000;
      push.res[cnt].last       = 1'b1;
      push.res[cnt].unit_count = units_emitted_next;
      cnt = cnt + 2'd1;
      units_emitted_next = 16'h0000;
      decode_mode_next   = utf8dec_pkg::MODE_IDLE;
      partial_value_next = 16'h0000;
      held_byte_next     = 8'h00;
    end

    push.n = accept ? cnt : 2'd0;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode   <= utf8dec_pkg::MODE_IDLE;
      partial_value <= 16'h0000;
      held_byte     <= 8'h00;
      units_emitted <= 16'h0000;
    end else if (accept) begin
      decode_mode   <= decode_mode_next;
      partial_value <= partial_value_next;
      held_byte     <= held_byte_next;
      units_emitted <= units_emitted_next;
    end
  end

  // A zero byte always leaves the decoder idle with a cleared count
  `U8D_ASSERT_NEXT(a_close_idle, accept && in_byte == 8'h00,
    decode_mode == utf8dec_pkg::MODE_IDLE && units_emitted == 16'h0000,
    "decoder not idle after terminator")

  // Nothing is pushed without an accepted byte
  `U8D_ASSERT_NOW(a_push_on_accept, !accept, push.n == 2'd0,
    "results pushed without an accepted byte")

  // A new character in idle gives at most one unit
  `U8D_ASSERT_NOW(a_idle_single,
    accept && decode_mode == utf8dec_pkg::MODE_IDLE && in_byte != 8'h00,
    push.n <= 2'd1,
    "more than one unit from a byte taken in idle")

endmodule

// ===== hw/rtl/utf8dec_fifo.sv =====
module utf8dec_fifo #(
  parameter int ADDR_W = utf8dec_pkg::FIFO_ADDR_W_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  utf8dec_pkg::push_t push,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        code_unit,
  output logic               last,
  output logic [15:0]        unit_count
);

  `include "utf8_to_ucs2_stream_decoder_top_assert.svh"

  localparam int DEPTH = 1 << ADDR_W;

  utf8dec_pkg::result_t        mem [DEPTH];
  logic [ADDR_W-1:0]           wr_ptr;
  logic [ADDR_W-1:0]           rd_ptr;
  logic [ADDR_W:0]             count;
  logic                        pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  // room for the worst-case burst of one byte
  assign space     = (count <= (ADDR_W + 1)'(DEPTH - utf8dec_pkg::MAX_RESULTS));

  // Result storage, up to three writes per cycle
  always_ff @(posedge clk) begin
    for (int i = 0; i < utf8dec_pkg::MAX_RESULTS; i++) begin
      if (2'(i) < push.n) begin
        mem[wr_ptr + ADDR_W'(i)] <= push.res[i];
      end
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ADDR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + ADDR_W'(1);
      end
      count <= count + (ADDR_W + 1)'(push.n) - (ADDR_W + 1)'(pop);
    end
  end

  // Head of the queue
  assign code_unit  = mem[rd_ptr].code_unit;
  assign last       = mem[rd_ptr].last;
  assign unit_count = mem[rd_ptr].unit_count;

  `U8D_ASSERT_NOW(a_no_overflow, 1'b1, count <= (ADDR_W + 1)'(DEPTH),
    "result queue overflow")
  `U8D_ASSERT_NOW(a_push_has_room, push.n != 2'd0, space,
    "results pushed without room")
  `U8D_ASSERT_NEXT(a_grow, push.n != 2'd0 && !pop, count > $past(count),
    "fill level did not grow on push")

endmodule
